@@ hw/rtl/mjd_bcd_start_time_codec_defines.svh @@
// ----------------------------------------------------------------------------
// mjd/bcd start time codec assertion macros
// shared property shapes for the codec's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MJD_BCD_START_TIME_CODEC_DEFINES_SVH
`define MJD_BCD_START_TIME_CODEC_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MBST_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define MBST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/mbst_pkg.sv @@
// ----------------------------------------------------------------------------
// mbst_pkg
// types, constants and small conversion tables of the start time codec
// ----------------------------------------------------------------------------
package mbst_pkg;

	localparam int NUM_STAGES = 7;
	localparam int OCC_W      = $clog2(NUM_STAGES + 1);

	localparam int YEAR_W  = 11;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int CODE_W  = 40;
	localparam int MJD_W   = 16;
	localparam int TIME_W  = 24;
	localparam int BYTE_W  = 8;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 88;

	typedef logic [NUM_STAGES-1:0] stage_en_t;

	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_DECODE = 1'b1
	} req_type_t;

	typedef struct packed {
		stage_en_t en;
		req_type_t last_req;
	} pipe_ctl_t;

	// encode: julian day offsets, folded with the mjd epoch into one 16-bit bias
	localparam logic [12:0] YEAR_OFS_A = 13'd4800;
	localparam logic [12:0] YEAR_OFS_B = 13'd4900;
	localparam logic [MJD_W-1:0] MJD_BIAS = MJD_W'((32075 + 2400001) % 65536);

	// x / 100 as (x * 5243) >> 19, exact for x below 8192
	localparam logic [12:0] DIV100_K = 13'd5243;

	// decode: century split points on mjd and the matching l+1 offsets
	localparam logic [MJD_W-1:0] MJD_SPLIT_LO = 16'd15079;
	localparam logic [MJD_W-1:0] MJD_SPLIT_HI = 16'd51604;
	localparam logic [MJD_W-1:0] X_OFS_LO     = 16'd21446;
	localparam logic [MJD_W-1:0] X_OFS_MID    = 16'd15078;
	localparam logic [MJD_W-1:0] X_OFS_HI     = 16'd51603;
	localparam logic [YEAR_W-1:0] YBASE_LO    = 11'd1800;
	localparam logic [YEAR_W-1:0] YBASE_MID   = 11'd1900;
	localparam logic [YEAR_W-1:0] YBASE_HI    = 11'd2000;

	// year-in-cycle estimate: floor(4000 * 2^24 / 1461001), off by at most one
	localparam logic [15:0] YCYC_K       = 16'd45933;
	localparam logic [20:0] YCYC_DIVISOR = 21'd1461001;

	// month estimate: floor(80 * 2^16 / 2447), off by at most one
	localparam logic [11:0] MON_K       = 12'd2142;
	localparam logic [11:0] MON_DIVISOR = 12'd2447;

	// binary 0..63 to two bcd digits, tens via (v * 205) >> 11
	function automatic logic [BYTE_W-1:0] bin_to_bcd(input logic [5:0] v);
		logic [13:0] prod;
		logic [2:0]  q;
		logic [5:0]  qx10;
		logic [5:0]  r;
		prod = 14'(v) * 14'd205;
		q    = prod[13:11];
		qx10 = {q, 3'b000} + {2'b00, q, 1'b0};
		r    = v - qx10;
		return {1'b0, q, r[3:0]};
	endfunction

	// two nibbles to high * 10 + low, no digit check
	function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] b);
		return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
	endfunction

	// floor(367 * (m - 2 - 12a) / 12), a = -1 for months up to february
	function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd305;
			4'd1:    t = 9'd336;
			4'd2:    t = 9'd367;
			4'd3:    t = 9'd30;
			4'd4:    t = 9'd61;
			4'd5:    t = 9'd91;
			4'd6:    t = 9'd122;
			4'd7:    t = 9'd152;
			4'd8:    t = 9'd183;
			4'd9:    t = 9'd214;
			4'd10:   t = 9'd244;
			4'd11:   t = 9'd275;
			4'd12:   t = 9'd305;
			4'd13:   t = 9'd336;
			4'd14:   t = 9'd367;
			default: t = 9'd397;
		endcase
		return t;
	endfunction

	// floor(2447 * j / 80)
	function automatic logic [8:0] day_offset(input logic [3:0] j);
		logic [8:0] t;
		case (j)
			4'd0:    t = 9'd0;
			4'd1:    t = 9'd30;
			4'd2:    t = 9'd61;
			4'd3:    t = 9'd91;
			4'd4:    t = 9'd122;
			4'd5:    t = 9'd152;
			4'd6:    t = 9'd183;
			4'd7:    t = 9'd214;
			4'd8:    t = 9'd244;
			4'd9:    t = 9'd275;
			4'd10:   t = 9'd305;
			4'd11:   t = 9'd336;
			4'd12:   t = 9'd367;
			4'd13:   t = 9'd397;
			4'd14:   t = 9'd428;
			default: t = 9'd458;
		endcase
		return t;
	endfunction

endpackage

@@ hw/rtl/mbst_ctl.sv @@
// ----------------------------------------------------------------------------
// mbst_ctl
// stage valid bits, per-stage load enables and beat occupancy
// ----------------------------------------------------------------------------
`include "mjd_bcd_start_time_codec_defines.svh"

module mbst_ctl
	import mbst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      s_tuser,
	output logic      m_tvalid,
	input  logic      m_tready,
	output pipe_ctl_t ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] typ_q;
	logic [OCC_W-1:0]      occ_q;
	stage_en_t             en;

	// a stage loads when it is empty or the stage after it moves
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready     = en[0];
	assign m_tvalid     = vld_q[NUM_STAGES-1];
	assign ctl.en       = en;
	assign ctl.last_req = req_type_t'(typ_q[NUM_STAGES-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			typ_q <= '0;
			occ_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[NUM_STAGES-2:0], s_tvalid}) | (~en & vld_q);
			typ_q <= (en & {typ_q[NUM_STAGES-2:0], s_tuser}) | (~en & typ_q);
			occ_q <= occ_q + OCC_W'(s_tvalid && s_tready) - OCC_W'(m_tvalid && m_tready);
		end
	end

	`MBST_ASSERT_HOLDS(a_occ_match, clk, arst_n, occ_q == OCC_W'($countones(vld_q)), "beat count and stage valids disagree")
	`MBST_ASSERT_HOLDS(a_ready_rule, clk, arst_n, s_tready == !((occ_q == OCC_W'(NUM_STAGES)) && !m_tready), "ready low while pipeline has room")
	`MBST_ASSERT_NEXT(a_first_stage, clk, arst_n, s_tvalid && s_tready, vld_q[0], "accepted beat missing from first stage")

endmodule

@@ hw/rtl/mbst_enc.sv @@
// ----------------------------------------------------------------------------
// mbst_enc
// gregorian date and binary time to the 40-bit mjd/bcd code
// ----------------------------------------------------------------------------
module mbst_enc
	import mbst_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	input  logic [HOUR_W-1:0]  hour,
	input  logic [MIN_W-1:0]   minute,
	input  logic [SEC_W-1:0]   second,
	output logic [CODE_W-1:0]  code
);

	logic              early;
	logic [12:0]       v_s1, w_s1;
	logic [8:0]        t2_s1, t2_s2;
	logic [DAY_W-1:0]  day_s1, day_s2;
	logic [TIME_W-1:0] tm_s1, tm_s2;
	logic [23:0]       p1_s2;
	logic [25:0]       w_prod;
	logic [6:0]        q100_s2;
	logic [8:0]        t3_prod;
	logic [MJD_W-1:0]  mjd;
	logic [CODE_W-1:0] code_s3, code_s4, code_s5, code_s6, code_s7;

	// january and february count as months of the previous year
	assign early = (month <= 4'd2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1   <= 13'(year) + YEAR_OFS_A - 13'(early);
			w_s1   <= 13'(year) + YEAR_OFS_B - 13'(early);
			t2_s1  <= month_term(month);
			day_s1 <= day;
			tm_s1  <= {bin_to_bcd(6'(hour)), bin_to_bcd(minute), bin_to_bcd(second)};
		end
	end

	assign w_prod = 26'(w_s1) * 26'(DIV100_K);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p1_s2   <= 24'(v_s1) * 24'd1461;
			q100_s2 <= w_prod[25:19];
			t2_s2   <= t2_s1;
			day_s2  <= day_s1;
			tm_s2   <= tm_s1;
		end
	end

	// only the low 16 bits of the julian day survive, so sum modulo 2^16
	assign t3_prod = 9'(q100_s2) * 9'd3;
	assign mjd = 16'(day_s2) + p1_s2[17:2] + 16'(t2_s2) - 16'(t3_prod[8:2]) - MJD_BIAS;

	always_ff @(posedge clk) begin
		if (en[2]) code_s3 <= {mjd, tm_s2};
		if (en[3]) code_s4 <= code_s3;
		if (en[4]) code_s5 <= code_s4;
		if (en[5]) code_s6 <= code_s5;
		if (en[6]) code_s7 <= code_s6;
	end

	assign code = code_s7;

endmodule

@@ hw/rtl/mbst_dec.sv @@
// ----------------------------------------------------------------------------
// mbst_dec
// 40-bit mjd/bcd code to gregorian date and binary time
// ----------------------------------------------------------------------------
module mbst_dec
	import mbst_pkg::*;
(
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [CODE_W-1:0]  code,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DAY_W-1:0]   day,
	output logic [BYTE_W-1:0]  hour,
	output logic [BYTE_W-1:0]  minute,
	output logic [BYTE_W-1:0]  second
);

	logic [MJD_W-1:0]  mjd;
	logic [MJD_W-1:0]  x_nxt;
	logic [YEAR_W-1:0] ybase_nxt;

	logic [MJD_W-1:0]  x_s1, x_s2, x_s3;
	logic [YEAR_W-1:0] ybase_s1, ybase_s2, ybase_s3, ybase_s4, ybase_s5, ybase_s6, ybase_s7;
	logic [TIME_W-1:0] tm_s1, tm_s2, tm_s3, tm_s4, tm_s5, tm_s6, tm_s7;
	logic [31:0]       ycyc_prod;
	logic [6:0]        est_s2;
	logic [27:0]       x4k_s2;
	logic [27:0]       ycyc_lim;
	logic [6:0]        i_s3, i_s4, i_s5, i_s6;
	logic [17:0]       i_prod;
	logic [16:0]       l3_full;
	logic [8:0]        l3_s4, l3_s5, l3_s6;
	logic [19:0]       mon_prod;
	logic [3:0]        estj_s5;
	logic [15:0]       l3x80, jlim;
	logic [3:0]        j_s6;
	logic              wrap;
	logic [8:0]        day_full;
	logic [MONTH_W-1:0] month_s7;
	logic [DAY_W-1:0]  day_s7;

	// stage 1: pick the century base, l + 1 relative to it
	assign mjd = code[39:24];

	always_comb begin
		if (mjd >= MJD_SPLIT_HI) begin
			x_nxt     = mjd - X_OFS_HI;
			ybase_nxt = YBASE_HI;
		end else if (mjd >= MJD_SPLIT_LO) begin
			x_nxt     = mjd - X_OFS_MID;
			ybase_nxt = YBASE_MID;
		end else begin
			x_nxt     = mjd + X_OFS_LO;
			ybase_nxt = YBASE_LO;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1     <= x_nxt;
			ybase_s1 <= ybase_nxt;
			tm_s1    <= {bcd_to_bin(code[23:16]), bcd_to_bin(code[15:8]), bcd_to_bin(code[7:0])};
		end
	end

	// stage 2: year estimate by reciprocal, plus the exact numerator
	assign ycyc_prod = 32'(x_s1) * 32'(YCYC_K);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			est_s2   <= ycyc_prod[30:24];
			x4k_s2   <= 28'(x_s1) * 28'd4000;
			x_s2     <= x_s1;
			ybase_s2 <= ybase_s1;
			tm_s2    <= tm_s1;
		end
	end

	// stage 3: bump the estimate when the next multiple still fits
	assign ycyc_lim = 28'(8'(est_s2) + 8'd1) * 28'(YCYC_DIVISOR);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			i_s3     <= est_s2 + 7'(x4k_s2 >= ycyc_lim);
			x_s3     <= x_s2;
			ybase_s3 <= ybase_s2;
			tm_s3    <= tm_s2;
		end
	end

	// stage 4: day within the march-based year, offset by 31
	assign i_prod  = 18'(i_s3) * 18'd1461;
	assign l3_full = 17'(x_s3) + 17'd30 - 17'(i_prod[17:2]);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			l3_s4    <= l3_full[8:0];
			i_s4     <= i_s3;
			ybase_s4 <= ybase_s3;
			tm_s4    <= tm_s3;
		end
	end

	// stage 5: month estimate
	assign mon_prod = 20'(l3_s4) * 20'(MON_K);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			estj_s5  <= mon_prod[19:16];
			l3_s5    <= l3_s4;
			i_s5     <= i_s4;
			ybase_s5 <= ybase_s4;
			tm_s5    <= tm_s4;
		end
	end

	// stage 6: correct the month estimate
	assign l3x80 = 16'(l3_s5) * 16'd80;
	assign jlim  = 16'(5'(estj_s5) + 5'd1) * 16'(MON_DIVISOR);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			j_s6     <= estj_s5 + 4'(l3x80 >= jlim);
			l3_s6    <= l3_s5;
			i_s6     <= i_s5;
			ybase_s6 <= ybase_s5;
			tm_s6    <= tm_s5;
		end
	end

	// stage 7: january and february roll into the next year
	assign wrap     = (j_s6 >= 4'd11);
	assign day_full = l3_s6 - day_offset(j_s6);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			month_s7 <= wrap ? (j_s6 - 4'd10) : (j_s6 + 4'd2);
			day_s7   <= day_full[DAY_W-1:0];
			ybase_s7 <= ybase_s6 + 11'(i_s6) + 11'(wrap);
			tm_s7    <= tm_s6;
		end
	end

	assign year   = ybase_s7;
	assign month  = month_s7;
	assign day    = day_s7;
	assign hour   = tm_s7[23:16];
	assign minute = tm_s7[15:8];
	assign second = tm_s7[7:0];

endmodule

@@ hw/rtl/mjd_bcd_start_time_codec.sv @@
// ----------------------------------------------------------------------------
// mjd_bcd_start_time_codec
// service-information start time codec: date/time <-> 16-bit mjd + bcd time
// ----------------------------------------------------------------------------
// usage
//   s_* carries request beats: s_tuser selects encode (date and binary time
//   to a 40-bit code) or decode (40-bit code to date and binary time).
//   m_* carries one result beat per request, in request order; fields that
//   the selected direction does not produce are zero.
// pipeline
//   seven register stages; a result beat is presented from the last of them.
//   one beat per cycle is accepted and delivered while m_tready is high;
//   the deepest stages are the year-in-cycle estimate and its correction,
//   a constant multiply each, the correction followed by a compare.
// reset
//   arst_n clears every stage valid bit; no result is pending afterwards.
// back-pressure
//   when m_tready is low the last stage holds its beat, upstream stages keep
//   loading into empty slots, and s_tready drops only once all seven stages
//   hold beats.
// ----------------------------------------------------------------------------
`include "mjd_bcd_start_time_codec_defines.svh"

module mjd_bcd_start_time_codec
	import mbst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// year[10:0] month[14:11] day[19:15] hour[24:20] minute[30:25]
	// second[36:31] code[76:37], zero above
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// code[39:0] year[50:40] month[54:51] day[59:55] hour[67:60]
	// minute[75:68] second[83:76], zero above
	output logic [M_TDATA_W-1:0] m_tdata
);

	// request fields
	logic [YEAR_W-1:0]  in_year;
	logic [MONTH_W-1:0] in_month;
	logic [DAY_W-1:0]   in_day;
	logic [HOUR_W-1:0]  in_hour;
	logic [MIN_W-1:0]   in_minute;
	logic [SEC_W-1:0]   in_second;
	logic [CODE_W-1:0]  in_code;

	assign in_year   = s_tdata[10:0];
	assign in_month  = s_tdata[14:11];
	assign in_day    = s_tdata[19:15];
	assign in_hour   = s_tdata[24:20];
	assign in_minute = s_tdata[30:25];
	assign in_second = s_tdata[36:31];
	assign in_code   = s_tdata[76:37];

	pipe_ctl_t ctl;

	// handshake, stage valids and the direction bit travel here
	mbst_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	logic [CODE_W-1:0] enc_code;

	// encode path computes on every beat; its result is dropped for decode
	mbst_enc u_enc (
		.clk    (clk),
		.en     (ctl.en),
		.year   (in_year),
		.month  (in_month),
		.day    (in_day),
		.hour   (in_hour),
		.minute (in_minute),
		.second (in_second),
		.code   (enc_code)
	);

	logic [YEAR_W-1:0]  dec_year;
	logic [MONTH_W-1:0] dec_month;
	logic [DAY_W-1:0]   dec_day;
	logic [BYTE_W-1:0]  dec_hour, dec_minute, dec_second;

	// decode path, same stage enables
	mbst_dec u_dec (
		.clk    (clk),
		.en     (ctl.en),
		.code   (in_code),
		.year   (dec_year),
		.month  (dec_month),
		.day    (dec_day),
		.hour   (dec_hour),
		.minute (dec_minute),
		.second (dec_second)
	);

	// result beat: unused direction's fields forced to zero
	logic is_dec;

	assign is_dec = (ctl.last_req == REQ_DECODE);

	assign m_tdata = {
		4'b0000,
		is_dec ? dec_second : {BYTE_W{1'b0}},
		is_dec ? dec_minute : {BYTE_W{1'b0}},
		is_dec ? dec_hour   : {BYTE_W{1'b0}},
		is_dec ? dec_day    : {DAY_W{1'b0}},
		is_dec ? dec_month  : {MONTH_W{1'b0}},
		is_dec ? dec_year   : {YEAR_W{1'b0}},
		is_dec ? {CODE_W{1'b0}} : enc_code
	};

	`MBST_ASSERT_IMPL(a_dec_date, clk, arst_n, m_tvalid && is_dec, dec_month >= 4'd1 && dec_month <= 4'd12 && dec_day >= 5'd1 && dec_day <= 5'd31, "decoded month or day out of range")
	`MBST_ASSERT_IMPL(a_dec_year, clk, arst_n, m_tvalid && is_dec, dec_year >= 11'd1858 && dec_year <= 11'd2038, "decoded year out of mjd span")
	`MBST_ASSERT_IMPL(a_enc_bcd, clk, arst_n, m_tvalid && !is_dec, enc_code[3:0] <= 4'd9 && enc_code[11:8] <= 4'd9 && enc_code[19:16] <= 4'd9, "encoded time digit above nine")

endmodule
